>>> sv/bba_pkg.sv
package bba_pkg;

   localparam int LVL_W  = 5;
   localparam int OFF_W  = 16;
   localparam int SIZE_W = 16;
   // block offsets travel at the widest pool size
   localparam int PTR_W  = 24;

   localparam int DEF_MAX_LEVEL    = 16;
   localparam int DEF_HEADER_BYTES = 16;

   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_FAIL,
      CMD_RELEASE,
      CMD_IGNORE
   } cmd_kind_type;

   typedef enum logic [1:0] {
      STATUS_GRANTED  = 2'd0,
      STATUS_FAILED   = 2'd1,
      STATUS_RELEASED = 2'd2,
      STATUS_IGNORED  = 2'd3
   } status_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [LVL_W-1:0]   level;
      logic [PTR_W-1:0]   blk;
   } cmd_type;

   typedef struct packed {
      status_type         status;
      logic [OFF_W-1:0]   offset;
      logic [LVL_W-1:0]   level;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_POP,
      ST_SPLIT,
      ST_REL_RD,
      ST_REL_CHK,
      ST_EMIT
   } back_state_type;

endpackage

>>> sv/buddy_block_allocator_top.sv
// channel   direction  handshake          word
// req_      in         push / full        mode, request_size, payload_offset
// rsp_      out        pop / empty        status, granted_offset, granted_level
//
// states after the accepting IDLE, up to EMIT, which queues the result
// and holds while the result queue is full; allocate: SEARCH up from
//   the needed level, POP, SPLIT down to it, EMIT; search and
//   split walk one level a cycle through the stack memory port
// release: REL_RD, REL_CHK, EMIT; bound by the registered level memory read
// allocate failed by the front and release ignored by the front: EMIT
// reset brings up the top level as the single free block; no clearing pass
// each side holds two words, so requests are taken while results wait
module buddy_block_allocator_top #(
   parameter int MAX_LEVEL    = bba_pkg::DEF_MAX_LEVEL,
   parameter int HEADER_BYTES = bba_pkg::DEF_HEADER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_mode,
   input  logic [15:0] req_request_size,
   input  logic [15:0] req_payload_offset,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_granted_offset,
   output logic [4:0]  rsp_granted_level
);
   import bba_pkg::*;

   // smallest level that still holds the header and one byte
   localparam int LOW_LEVEL = ($clog2(HEADER_BYTES + 1) < MAX_LEVEL)
                            ? $clog2(HEADER_BYTES + 1) : MAX_LEVEL;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;
   rsp_type rsp;

   // front: sizes to levels, release checks that need no state
   bba_front #(
      .MAX_LEVEL    (MAX_LEVEL),
      .HEADER_BYTES (HEADER_BYTES),
      .LOW_LEVEL    (LOW_LEVEL)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_mode           (req_mode),
      .req_request_size   (req_request_size),
      .req_payload_offset (req_payload_offset),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop)
   );

   // back: free stacks, splitting and the level table
   bba_back #(
      .MAX_LEVEL    (MAX_LEVEL),
      .HEADER_BYTES (HEADER_BYTES),
      .LOW_LEVEL    (LOW_LEVEL)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_status         = rsp.status;
   assign rsp_granted_offset = rsp.offset;
   assign rsp_granted_level  = rsp.level;

   // back never takes a command the front does not hold
   a_cmd_pop: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from empty queue");

   // a grant names a level inside the pool
   a_grant_level: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == STATUS_GRANTED) |->
         (rsp_granted_level >= 5'(LOW_LEVEL) && rsp_granted_level <= 5'(MAX_LEVEL)))
      else $error("granted level out of range");

   // anything but a grant carries zero offset and level
   a_nongrant_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != STATUS_GRANTED) |->
         (rsp_granted_offset == '0 && rsp_granted_level == '0))
      else $error("non-grant word carries data");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!req_full && rsp_empty))
      else $error("queues not clear after reset");

endmodule

>>> sv/bba_ram.sv
module bba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bba_front.sv
module bba_front #(
   parameter int MAX_LEVEL    = 16,
   parameter int HEADER_BYTES = 16,
   parameter int LOW_LEVEL    = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_mode,
   input  logic [15:0]      req_request_size,
   input  logic [15:0]      req_payload_offset,
   output logic             cmd_valid,
   output bba_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   import bba_pkg::*;

   localparam logic [OFF_W-1:0] GRAN_MASK = OFF_W'((1 << LOW_LEVEL) - 1);

   logic [SIZE_W:0]   need;
   logic [SIZE_W:0]   need_m1;
   logic [LVL_W-1:0]  lv;
   logic [OFF_W-1:0]  blk16;
   logic              rel_bad;
   cmd_type           cls;

   cmd_type           q_ff [0:1];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              push_ok, pop_ok;

   // ceil(log2(size + header)) by the top set bit of need - 1
   always_comb begin
      need    = {1'b0, req_request_size} + (SIZE_W+1)'(HEADER_BYTES);
      need_m1 = need - 1'b1;
      lv      = '0;
      for (int k = 0; k <= SIZE_W; k++) begin
         if (need_m1[k]) begin
            lv = LVL_W'(k + 1);
         end
      end
   end

   always_comb begin
      blk16   = req_payload_offset - OFF_W'(HEADER_BYTES);
      rel_bad = (req_payload_offset < OFF_W'(HEADER_BYTES))
             || ((blk16 >> MAX_LEVEL) != '0)
             || ((blk16 & GRAN_MASK) != '0);
   end

   always_comb begin
      cls.level = '0;
      cls.blk   = '0;
      if (!req_mode) begin
         if (req_request_size == '0 || lv > LVL_W'(MAX_LEVEL)) begin
            cls.kind = CMD_FAIL;
         end else begin
            cls.kind  = CMD_ALLOC;
            cls.level = (lv < LVL_W'(LOW_LEVEL)) ? LVL_W'(LOW_LEVEL) : lv;
         end
      end else if (rel_bad) begin
         cls.kind = CMD_IGNORE;
      end else begin
         cls.kind = CMD_RELEASE;
         cls.blk  = PTR_W'(blk16);
      end
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cls;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop_ok) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
      end
   end

endmodule

>>> sv/bba_back.sv
module bba_back #(
   parameter int MAX_LEVEL    = 16,
   parameter int HEADER_BYTES = 16,
   parameter int LOW_LEVEL    = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  bba_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output bba_pkg::rsp_type rsp
);
   import bba_pkg::*;

   localparam int D   = MAX_LEVEL - LOW_LEVEL;
   localparam int AW  = D + 1;
   localparam int CW  = D + 1;
   localparam int TAW = (D > 0) ? D : 1;
   localparam int LW  = $clog2(MAX_LEVEL + 1);
   localparam int BW  = MAX_LEVEL;

   back_state_type    state_ff, state_in;
   logic [LVL_W-1:0]  cur_ff, cur_in;
   logic [LVL_W-1:0]  need_ff, need_in;
   logic [BW-1:0]     blk_ff, blk_in;
   rsp_type           res_ff, res_in;
   logic [CW-1:0]     cnt_ff [0:MAX_LEVEL];

   logic [LVL_W-1:0]  sel_lvl;
   logic [CW-1:0]     sel_cnt;
   logic [CW:0]       sel_cap;
   logic              has_room, search_end, search_hit, split_more;
   logic              rel_ok;
   logic [BW:0]       align_mask;

   logic              cnt_we;
   logic [CW-1:0]     cnt_val;
   logic              st_we;
   logic [AW-1:0]     st_waddr, st_raddr;
   logic [BW-1:0]     st_wdata, st_rdata;
   logic              tb_we;
   logic [TAW-1:0]    tb_addr;
   logic [LVL_W-1:0]  tb_rdata;
   logic              rsp_push;

   rsp_type           rq_ff [0:1];
   logic              rq_wr_ff, rq_rd_ff;
   logic [1:0]        rq_count_ff;
   logic              rq_full, rq_pop_ok;

   // start of a level's region in the stack store
   function automatic logic [AW-1:0] base_of(input logic [LVL_W-1:0] lv);
      logic [AW:0] top_v;
      logic [AW:0] sub_v;
      top_v = (AW+1)'(1) << AW;
      sub_v = (AW+1)'(1) << (LVL_W'(MAX_LEVEL + 1) - lv);
      return AW'(top_v - sub_v);
   endfunction

   bba_ram #(.WIDTH(BW), .DEPTH(1 << AW)) u_stack_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   bba_ram #(.WIDTH(LVL_W), .DEPTH(1 << TAW)) u_level_ram (
      .clock   (clock),
      .wr_en   (tb_we),
      .wr_addr (tb_addr),
      .wr_data (need_ff),
      .rd_addr (tb_addr),
      .rd_data (tb_rdata)
   );

   always_comb begin
      case (state_ff)
         ST_SPLIT:   sel_lvl = cur_ff - 1'b1;
         ST_REL_CHK: sel_lvl = tb_rdata;
         default:    sel_lvl = cur_ff;
      endcase
   end

   always_comb begin
      sel_cnt    = cnt_ff[sel_lvl[LW-1:0]];
      sel_cap    = (CW+1)'(1) << (LVL_W'(MAX_LEVEL) - sel_lvl);
      has_room   = ({1'b0, sel_cnt} < sel_cap);
      search_end = (cur_ff > LVL_W'(MAX_LEVEL));
      search_hit = !search_end && (sel_cnt != '0);
      split_more = (cur_ff > need_ff);
      align_mask = ((BW+1)'(1) << tb_rdata) - 1'b1;
      rel_ok     = (tb_rdata >= LVL_W'(LOW_LEVEL)) && (tb_rdata <= LVL_W'(MAX_LEVEL))
                && ((blk_ff & align_mask[BW-1:0]) == '0) && has_room;
      tb_addr    = TAW'(blk_ff >> LOW_LEVEL);
      st_waddr   = base_of(sel_lvl) + sel_cnt;
      st_raddr   = base_of(cur_ff) + sel_cnt - 1'b1;
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_valid) begin
               state_in = ST_IDLE;
            end else begin
               case (cmd.kind)
                  CMD_ALLOC:   state_in = ST_SEARCH;
                  CMD_RELEASE: state_in = ST_REL_RD;
                  default:     state_in = ST_EMIT;
               endcase
            end
         end
         ST_SEARCH: begin
            if (search_end) begin
               state_in = ST_EMIT;
            end else if (search_hit) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_POP:     state_in = ST_SPLIT;
         ST_SPLIT:   state_in = split_more ? ST_SPLIT : ST_EMIT;
         ST_REL_RD:  state_in = ST_REL_CHK;
         ST_REL_CHK: state_in = ST_EMIT;
         ST_EMIT:    state_in = rq_full ? ST_EMIT : ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cur_in   = cur_ff;
      need_in  = need_ff;
      blk_in   = blk_ff;
      res_in   = res_ff;
      cmd_pop  = 1'b0;
      cnt_we   = 1'b0;
      cnt_val  = sel_cnt;
      st_we    = 1'b0;
      st_wdata = blk_ff;
      tb_we    = 1'b0;
      rsp_push = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd_pop = cmd_valid;
            cur_in  = cmd.level;
            need_in = cmd.level;
            blk_in  = cmd.blk[BW-1:0];
            res_in  = '{status: STATUS_IGNORED, offset: '0, level: '0};
            if (cmd.kind == CMD_FAIL) begin
               res_in.status = STATUS_FAILED;
            end
         end
         ST_SEARCH: begin
            if (search_end) begin
               res_in = '{status: STATUS_FAILED, offset: '0, level: '0};
            end else if (search_hit) begin
               cnt_we  = 1'b1;
               cnt_val = sel_cnt - 1'b1;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         ST_POP: begin
            // the top level only ever holds the block at offset zero
            blk_in = (cur_ff == LVL_W'(MAX_LEVEL)) ? '0 : st_rdata;
         end
         ST_SPLIT: begin
            if (split_more) begin
               cur_in   = cur_ff - 1'b1;
               st_wdata = blk_ff + (BW'(1) << sel_lvl);
               st_we    = has_room;
               cnt_we   = has_room;
               cnt_val  = sel_cnt + 1'b1;
            end else begin
               tb_we  = 1'b1;
               res_in = '{status: STATUS_GRANTED,
                          offset: OFF_W'(32'(blk_ff) + 32'(HEADER_BYTES)),
                          level: need_ff};
            end
         end
         ST_REL_CHK: begin
            st_we   = rel_ok;
            cnt_we  = rel_ok;
            cnt_val = sel_cnt + 1'b1;
            res_in  = '{status: rel_ok ? STATUS_RELEASED : STATUS_IGNORED,
                        offset: '0, level: '0};
         end
         ST_EMIT: begin
            rsp_push = !rq_full;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      need_ff <= need_in;
      blk_ff  <= blk_in;
      res_ff  <= res_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int k = 0; k <= MAX_LEVEL; k++) begin
            cnt_ff[k] <= (k == MAX_LEVEL) ? CW'(1) : '0;
         end
      end else begin
         state_ff <= state_in;
         if (cnt_we) begin
            cnt_ff[sel_lvl[LW-1:0]] <= cnt_val;
         end
      end
   end

   // result queue
   assign rq_full   = (rq_count_ff == 2'd2);
   assign rsp_empty = (rq_count_ff == 2'd0);
   assign rsp       = rq_ff[rq_rd_ff];
   assign rq_pop_ok = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rq_ff[rq_wr_ff] <= res_ff;
      end
      if (reset) begin
         rq_wr_ff    <= 1'b0;
         rq_rd_ff    <= 1'b0;
         rq_count_ff <= 2'd0;
      end else begin
         if (rsp_push) begin
            rq_wr_ff <= ~rq_wr_ff;
         end
         if (rq_pop_ok) begin
            rq_rd_ff <= ~rq_rd_ff;
         end
         rq_count_ff <= rq_count_ff + {1'b0, rsp_push} - {1'b0, rq_pop_ok};
      end
   end

endmodule
